// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both forms are clocked on the rising edge and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/wlg_pkg.sv =====
package wlg_pkg;

  // Pixel modes
  localparam logic [1:0] MODE_GREY8  = 2'd0;
  localparam logic [1:0] MODE_GREY16 = 2'd1;
  localparam logic [1:0] MODE_RGB8   = 2'd2;
  localparam logic [1:0] MODE_RGB16  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_PIXEL_MODE  = 2'd0;
  localparam logic [1:0] REG_LOW_BORDER  = 2'd1;
  localparam logic [1:0] REG_HIGH_BORDER = 2'd2;

  localparam logic [15:0] HIGH_BORDER_RESET = 16'd255;
  localparam logic [15:0] BYTE_MAX          = 16'd255;

  // Step size: floor(t / 255) = (t * 32897) >> 23 for every 16-bit t
  localparam logic [15:0] STEP_RECIP = 16'd32897;
  localparam int          STEP_SHIFT = 23;

  // Window setup divider: 33-bit dividend, one quotient bit per cycle
  localparam int          DIV_BITS  = 33;
  localparam logic [5:0]  DIV_LAST  = 6'd33;

  // Floor divide by three for sums up to 765: (x * 683) >> 11
  localparam logic [19:0] DIV3_MUL   = 20'd683;
  localparam int          DIV3_SHIFT = 11;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_LOAD_T,
    SU_LOAD_M,
    SU_DIV_M,
    SU_LOAD_F,
    SU_DIV_F
  } su_state_t;

  // Window constants derived from the borders
  typedef struct packed {
    logic [8:0]  d;      // step size
    logic [31:0] recip;  // floor((2^32 - 1) / d)
    logic [16:0] first;  // ceil(low / d)
  } win_div_t;

  // Everything a lane needs to map one sample
  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
    win_div_t    div;
    logic        eight;
    logic        bypass;
  } lane_cfg_t;

endpackage

// ===== sv/window_level_grey_mapper.sv =====
// Window/level mapper: turns 8- or 16-bit pixel samples into 8-bit display levels.
// Input channel: in_valid / in_stall with sample_0..2 and frame_end, one word per clock.
// Output channel: out_valid / out_stall with level_0..2, grey_level and frame_end_out.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 pixel_mode,
// 1 low_border, 2 high_border); write only while no pixel is in flight.
// Throughput: one pixel per clock while in_stall is low. A pixel passes through
// four register stages: the three lane stages (compare and reciprocal multiply,
// remainder, step count) plus the output register that forms the grey average.
// After reset and after every register write a setup sequencer derives the step
// size with a multiply by the reciprocal of 255, then its reciprocal and the first
// step index with a bit-serial divider, each division after its own load state.
// in_stall stays high until the sequencer is back in idle.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset restores pixel_mode 0, low_border 0, high_border 255 and empties the pipe.
`include "assert_macros.svh"

module window_level_grey_mapper #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sample_0,
  input  logic [15:0] sample_1,
  input  logic [15:0] sample_2,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  level_0,
  output logic [7:0]  level_1,
  output logic [7:0]  level_2,
  output logic [7:0]  grey_level,
  output logic        frame_end_out
);

  logic [1:0]  pixel_mode;
  logic [15:0] low_border;
  logic [15:0] high_border;

  logic               busy;
  wlg_pkg::win_div_t  win;
  wlg_pkg::lane_cfg_t lane_cfg;

  logic adv;
  logic accept;
  logic v1, v2, v3;
  logic fe1, fe2, fe3;

  logic [7:0]  l0, l1, l2;
  logic        rgb;
  logic        grey_only;
  logic [9:0]  sum;
  logic [19:0] grey_prod;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode  <= wlg_pkg::MODE_GREY8;
      low_border  <= 16'd0;
      high_border <= wlg_pkg::HIGH_BORDER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wlg_pkg::REG_PIXEL_MODE:  pixel_mode  <= cfg_data[1:0];
        wlg_pkg::REG_LOW_BORDER:  low_border  <= cfg_data;
        wlg_pkg::REG_HIGH_BORDER: high_border <= cfg_data;
        default:                  pixel_mode  <= pixel_mode;
      endcase
    end
  end

  wlg_setup u_setup (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .low_border  (low_border),
    .high_border (high_border),
    .busy        (busy),
    .win         (win)
  );

  // Mode decode shared by the lanes
  always_comb begin
    lane_cfg.low    = low_border;
    lane_cfg.high   = high_border;
    lane_cfg.div    = win;
    lane_cfg.eight  = pixel_mode inside {wlg_pkg::MODE_GREY8, wlg_pkg::MODE_RGB8};
    lane_cfg.bypass = lane_cfg.eight && (low_border == 16'd0) &&
                      (high_border == wlg_pkg::BYTE_MAX);
  end

  // Pipeline handshake: advance unless a finished word is held by the receiver
  assign adv      = !(out_valid && out_stall);
  assign in_stall = busy || !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= accept;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fe1           <= frame_end;
      fe2           <= fe1;
      fe3           <= fe2;
      frame_end_out <= fe3;
    end
  end

  wlg_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane0 (
    .clk (clk), .adv (adv), .cfg (lane_cfg), .sample (sample_0), .level (l0)
  );

  wlg_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (
    .clk (clk), .adv (adv), .cfg (lane_cfg), .sample (sample_1), .level (l1)
  );

  wlg_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane2 (
    .clk (clk), .adv (adv), .cfg (lane_cfg), .sample (sample_2), .level (l2)
  );

  // Output stage: drop unused channels, average the three levels in RGB8 mode
  assign rgb       = (pixel_mode == wlg_pkg::MODE_RGB8) || (pixel_mode == wlg_pkg::MODE_RGB16);
  assign grey_only = !rgb;
  assign sum       = {2'b00, l0} + {2'b00, l1} + {2'b00, l2};
  assign grey_prod = {10'd0, sum} * wlg_pkg::DIV3_MUL;

  always_ff @(posedge clk) begin
    if (adv) begin
      level_0    <= l0;
      level_1    <= grey_only ? 8'd0 : l1;
      level_2    <= grey_only ? 8'd0 : l2;
      grey_level <= (pixel_mode == wlg_pkg::MODE_RGB8) ?
                    grey_prod[wlg_pkg::DIV3_SHIFT+7:wlg_pkg::DIV3_SHIFT] : l0;
    end
  end

  `ASSERT_IMPL(a_grey_unused_zero, clk, rst, out_valid && grey_only, level_1 == 8'd0 && level_2 == 8'd0, "unused channel levels not zero in a grey mode")
  `ASSERT_IMPL(a_grey_avg_bound, clk, rst, out_valid && (pixel_mode == wlg_pkg::MODE_RGB8), grey_level <= level_0 || grey_level <= level_1 || grey_level <= level_2, "grey average above all three levels")
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall, $stable(v1) && $stable(v2) && $stable(v3) && $stable(level_0), "pipeline moved while the output was stalled")
  `ASSERT_IMPL(a_no_accept_in_setup, clk, rst, busy && (v1 || v2 || v3), 1'b0, "setup running with pixels in flight")

endmodule

// ===== sv/wlg_setup.sv =====
module wlg_setup (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       low_border,
  input  logic [15:0]       high_border,
  output logic              busy,
  output wlg_pkg::win_div_t win
);

  wlg_pkg::su_state_t state;
  wlg_pkg::su_state_t state_next;

  logic [5:0]  cnt;
  logic [32:0] num;
  logic [8:0]  rem;
  logic [8:0]  dvs;
  logic [8:0]  d_reg;
  logic [31:0] recip;
  logic [16:0] first;

  logic        load;
  logic        step;
  logic        load_d;
  logic        done_m;
  logic        done_f;
  logic [32:0] num_load;
  logic [8:0]  dvs_load;
  logic [9:0]  rem_sh;
  logic        ge;
  logic [15:0] width_t;
  logic [31:0] t_prod;
  logic [16:0] low_round;

  assign width_t   = high_border - low_border;
  // Divide the window width by 255 with a reciprocal multiply
  assign t_prod    = {16'd0, width_t} * {16'd0, wlg_pkg::STEP_RECIP};
  assign low_round = {1'b0, low_border} + {8'd0, d_reg} - 17'd1;

  // Next state; a register write restarts the whole setup
  always_comb begin
    state_next = state;
    case (state)
      wlg_pkg::SU_IDLE:   state_next = wlg_pkg::SU_IDLE;
      wlg_pkg::SU_LOAD_T: state_next = wlg_pkg::SU_LOAD_M;
      wlg_pkg::SU_LOAD_M: state_next = wlg_pkg::SU_DIV_M;
      wlg_pkg::SU_DIV_M:  if (cnt == wlg_pkg::DIV_LAST) state_next = wlg_pkg::SU_LOAD_F;
      wlg_pkg::SU_LOAD_F: state_next = wlg_pkg::SU_DIV_F;
      wlg_pkg::SU_DIV_F:  if (cnt == wlg_pkg::DIV_LAST) state_next = wlg_pkg::SU_IDLE;
      default:            state_next = wlg_pkg::SU_LOAD_T;
    endcase
    if (cfg_we) state_next = wlg_pkg::SU_LOAD_T;
  end

  // Decode controls from the state
  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    load_d   = 1'b0;
    done_m   = 1'b0;
    done_f   = 1'b0;
    num_load = '0;
    dvs_load = d_reg;
    case (state)
      wlg_pkg::SU_LOAD_T: begin
        load_d = 1'b1;
      end
      wlg_pkg::SU_LOAD_M: begin
        load     = 1'b1;
        num_load = {1'b0, 32'hFFFF_FFFF};
        dvs_load = d_reg;
      end
      wlg_pkg::SU_LOAD_F: begin
        load     = 1'b1;
        num_load = {16'd0, low_round};
        dvs_load = d_reg;
      end
      wlg_pkg::SU_DIV_M: begin
        step   = 1'b1;
        done_m = (cnt == wlg_pkg::DIV_LAST);
      end
      wlg_pkg::SU_DIV_F: begin
        step   = 1'b1;
        done_f = (cnt == wlg_pkg::DIV_LAST);
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign busy = (state != wlg_pkg::SU_IDLE);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem, num[wlg_pkg::DIV_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wlg_pkg::SU_LOAD_T;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath and captured results
  always_ff @(posedge clk) begin
    if (load) begin
      num <= num_load;
      dvs <= dvs_load;
      rem <= 9'd0;
      cnt <= 6'd0;
    end else if (step && (cnt != wlg_pkg::DIV_LAST)) begin
      num <= {num[wlg_pkg::DIV_BITS-2:0], ge};
      rem <= ge ? 9'(rem_sh - {1'b0, dvs}) : rem_sh[8:0];
      cnt <= cnt + 6'd1;
    end
    if (load_d) d_reg <= t_prod[wlg_pkg::STEP_SHIFT+8:wlg_pkg::STEP_SHIFT] + 9'd1;
    if (done_m) recip <= num[31:0];
    if (done_f) first <= num[16:0];
  end

  assign win.d     = d_reg;
  assign win.recip = recip;
  assign win.first = first;

endmodule

// ===== sv/wlg_lane.sv =====
module wlg_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               adv,
  input  wlg_pkg::lane_cfg_t cfg,
  input  logic [15:0]        sample,
  output logic [7:0]         level
);

  localparam logic [15:0] SampleMask = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [15:0] v;
  logic [15:0] v1;
  logic [47:0] prod1;
  logic        below1;
  logic        above1;

  logic [15:0] q_est;
  logic [24:0] qd;
  logic [15:0] q2;
  logic [16:0] rem2;
  logic [7:0]  byte2;
  logic        below2;
  logic        above2;

  logic [16:0] q;
  logic [16:0] qp1;
  logic [16:0] count;
  logic [7:0]  level_next;

  // Stage 1: trim the sample, compare against the borders, multiply by 1/d
  assign v = cfg.eight ? {8'h00, sample[7:0]} : (sample & SampleMask);

  always_ff @(posedge clk) begin
    if (adv) begin
      v1     <= v;
      prod1  <= {32'd0, v} * {16'd0, cfg.div.recip};
      below1 <= (v < cfg.low);
      above1 <= (v >= cfg.high);
    end
  end

  // Stage 2: estimated quotient is exact or one short; form the remainder
  assign q_est = prod1[47:32];
  assign qd    = {9'd0, q_est} * {16'd0, cfg.div.d};

  always_ff @(posedge clk) begin
    if (adv) begin
      q2     <= q_est;
      rem2   <= {1'b0, v1} - qd[16:0];
      byte2  <= v1[7:0];
      below2 <= below1;
      above2 <= above1;
    end
  end

  // Stage 3: correct the quotient and count steps from the low border
  assign q     = {1'b0, q2} + ((rem2 >= {8'd0, cfg.div.d}) ? 17'd1 : 17'd0);
  assign qp1   = q + 17'd1;
  assign count = qp1 - cfg.div.first;

  always_comb begin
    if (cfg.bypass) begin
      level_next = byte2;
    end else if (below2) begin
      level_next = 8'd0;
    end else if (above2) begin
      level_next = 8'hFF;
    end else if (qp1 < cfg.div.first) begin
      level_next = 8'd0;
    end else begin
      level_next = count[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level <= level_next;
    end
  end

endmodule

// ===== verif/level_checker.sv =====
`timescale 1ns / 1ps

module level_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] sample_0,
  input  logic [15:0] sample_1,
  input  logic [15:0] sample_2,
  input  logic        frame_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  level_0,
  input  logic [7:0]  level_1,
  input  logic [7:0]  level_2,
  input  logic [7:0]  grey_level,
  input  logic        frame_end_out,
  output int          pending,
  output int          fail_count,
  output int          checked
);

  localparam int REPORT_LIMIT = 10;
  localparam int RING_DEPTH   = 16;

  typedef struct packed {
    logic [7:0] level_0;
    logic [7:0] level_1;
    logic [7:0] level_2;
    logic [7:0] grey;
    logic       frame_end;
  } level_word_t;

  // Shadow copy of the register file
  logic [1:0]  mode_reg;
  logic [15:0] low_reg;
  logic [15:0] high_reg;

  // Predicted words waiting for their output
  level_word_t want_ring[RING_DEPTH];
  logic [3:0]  wr_ptr      = 4'd0;
  logic [3:0]  rd_ptr      = 4'd0;
  int          outstanding = 0;
  int          errors      = 0;
  int          results     = 0;

  // Count the steps of size d that fall in [lo, v]; clamp outside the window
  function automatic logic [7:0] window_map(input logic [15:0] v, input logic [15:0] lo,
                                             input logic [15:0] hi);
    int unsigned span, step, first_step, last_step;
    if (v < lo) return 8'd0;
    if (v >= hi) return 8'd255;
    span       = hi - lo;
    step       = span / 255 + 1;
    first_step = (lo + step - 1) / step;
    last_step  = v / step;
    if (last_step + 1 < first_step) return 8'd0;
    return 8'(last_step + 1 - first_step);
  endfunction

  function automatic level_word_t predict_levels(input logic [15:0] s0, input logic [15:0] s1,
                                                 input logic [15:0] s2, input logic fe);
    logic        eight;
    logic [15:0] mask;
    logic [15:0] a, b, c;
    logic [9:0]  sum;
    level_word_t w;
    eight = (mode_reg == wlg_pkg::MODE_GREY8) || (mode_reg == wlg_pkg::MODE_RGB8);
    mask  = eight ? 16'h00FF : 16'((32'd1 << SAMPLE_BITS) - 1);
    a     = s0 & mask;
    b     = s1 & mask;
    c     = s2 & mask;
    w     = '0;
    if (eight && low_reg == 16'd0 && high_reg == wlg_pkg::BYTE_MAX) begin
      // 8-bit bypass: pass the bytes straight through
      w.level_0 = a[7:0];
      if (mode_reg == wlg_pkg::MODE_RGB8) begin
        w.level_1 = b[7:0];
        w.level_2 = c[7:0];
      end
    end else begin
      w.level_0 = window_map(a, low_reg, high_reg);
      if (mode_reg == wlg_pkg::MODE_RGB8 || mode_reg == wlg_pkg::MODE_RGB16) begin
        w.level_1 = window_map(b, low_reg, high_reg);
        w.level_2 = window_map(c, low_reg, high_reg);
      end
    end
    sum         = w.level_0 + w.level_1 + w.level_2;
    w.grey      = (mode_reg == wlg_pkg::MODE_RGB8) ? 8'(sum / 3) : w.level_0;
    w.frame_end = fe;
    return w;
  endfunction

  // Compare on delivery, predict on accept, track register writes
  always @(posedge clk) begin : watch
    level_word_t want;
    level_word_t got;
    if (rst) begin
      wr_ptr      = 4'd0;
      rd_ptr      = 4'd0;
      outstanding = 0;
      mode_reg    = wlg_pkg::MODE_GREY8;
      low_reg     = 16'd0;
      high_reg    = wlg_pkg::HIGH_BORDER_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        got.level_0   = level_0;
        got.level_1   = level_1;
        got.level_2   = level_2;
        got.grey      = grey_level;
        got.frame_end = frame_end_out;
        if (outstanding == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected output word l0=%0d l1=%0d l2=%0d grey=%0d fe=%0b",
                     $realtime, got.level_0, got.level_1, got.level_2, got.grey,
                     got.frame_end);
        end else begin
          want   = want_ring[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
          outstanding--;
          results++;
          if (got.level_0 !== want.level_0 || got.level_1 !== want.level_1 ||
              got.level_2 !== want.level_2 || got.grey !== want.grey ||
              got.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: word %0d mismatch: expected l0=%0d l1=%0d l2=%0d grey=%0d fe=%0b",
                       $realtime, results, want.level_0, want.level_1, want.level_2,
                       want.grey, want.frame_end);
              $display("    got l0=%0d l1=%0d l2=%0d grey=%0d fe=%0b",
                       got.level_0, got.level_1, got.level_2, got.grey, got.frame_end);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (outstanding == RING_DEPTH) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: more than %0d words in flight", $realtime, RING_DEPTH);
        end else begin
          want_ring[wr_ptr] = predict_levels(sample_0, sample_1, sample_2, frame_end);
          wr_ptr = wr_ptr + 4'd1;
          outstanding++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          wlg_pkg::REG_PIXEL_MODE:  mode_reg = cfg_data[1:0];
          wlg_pkg::REG_LOW_BORDER:  low_reg  = cfg_data;
          wlg_pkg::REG_HIGH_BORDER: high_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= outstanding;
    fail_count <= errors;
    checked    <= results;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int PIPE_LATENCY = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1250;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = wlg_pkg::REG_PIXEL_MODE;
  logic [15:0] cfg_data  = 16'd0;
  logic        in_valid  = 1'b0;
  logic [15:0] sample_0  = 16'd0;
  logic [15:0] sample_1  = 16'd0;
  logic [15:0] sample_2  = 16'd0;
  logic        frame_end = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  level_0;
  logic [7:0]  level_1;
  logic [7:0]  level_2;
  logic [7:0]  grey_level;
  logic        frame_end_out;

  int          pending;
  int          fail_count;
  int          checked;
  int          cycle_count   = 0;
  int          windows_set   = 0;
  logic [3:0]  modes_seen    = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  window_level_grey_mapper #(.SAMPLE_BITS(16)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .frame_end(frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_0(level_0), .level_1(level_1), .level_2(level_2),
    .grey_level(grey_level), .frame_end_out(frame_end_out)
  );

  level_checker #(.SAMPLE_BITS(16)) level_chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .frame_end(frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_0(level_0), .level_1(level_1), .level_2(level_2),
    .grey_level(grey_level), .frame_end_out(frame_end_out),
    .pending(pending), .fail_count(fail_count), .checked(checked)
  );

  always #4 clk = ~clk;

  // Stall the output side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one pixel word, with an optional gap first, and hold it until taken
  task automatic send_pixel(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                            input logic fe);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_0 <= a;
    sample_1 <= b;
    sample_2 <= c;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every predicted word has come out
  task automatic drain_pipe;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Write all three registers back to back on an idle pipe
  task automatic set_window(input logic [1:0] mode, input logic [15:0] lo,
                            input logic [15:0] hi);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_index <= wlg_pkg::REG_PIXEL_MODE;
    cfg_data  <= {14'd0, mode};
    @(posedge clk);
    cfg_index <= wlg_pkg::REG_LOW_BORDER;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= wlg_pkg::REG_HIGH_BORDER;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    windows_set++;
    modes_seen[mode] = 1'b1;
  endtask

  // Choose a mode and window, favoring step-size edges and odd windows
  task automatic pick_window(output logic [1:0] mode, output logic [15:0] lo,
                             output logic [15:0] hi);
    int unsigned span;
    int unsigned step_edges[7] = '{254, 255, 256, 509, 510, 764, 765};
    mode = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: begin lo = 16'd0; hi = wlg_pkg::BYTE_MAX; end
      1: begin lo = 16'd0; hi = 16'hFFFF; end
      2: begin
        lo = 16'($urandom_range(254));
        hi = 16'($urandom_range(255, lo + 1));
      end
      3: begin
        lo   = 16'($urandom);
        span = $urandom_range(600, 1);
        hi   = (lo + span > 65535) ? 16'hFFFF : 16'(lo + span);
      end
      5: begin
        // inverted window
        hi = 16'($urandom_range(65534));
        lo = 16'($urandom_range(65535, hi + 1));
      end
      6: begin
        // empty window
        lo = 16'($urandom);
        hi = lo;
      end
      7: begin
        lo = 16'($urandom_range(1000));
        hi = lo + 16'(step_edges[$urandom_range(6)]);
      end
      8: begin
        // window beyond the 8-bit range
        lo = 16'($urandom_range(65535, 256));
        hi = 16'($urandom_range(65535, lo));
      end
      9: begin
        case ($urandom_range(3))
          0: begin lo = 16'd0;    hi = 16'd0;    end
          1: begin lo = 16'hFFFF; hi = 16'hFFFF; end
          2: begin lo = 16'hFFFF; hi = 16'd0;    end
          default: begin lo = 16'd0; hi = 16'hFFFF; end
        endcase
      end
      default: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
    endcase
  endtask

  // Sample values clustered on the window edges, with junk above the byte
  function automatic logic [15:0] pick_sample(input logic eight, input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] v;
    case ($urandom_range(9))
      3: v = lo + 16'($urandom_range(4)) - 16'd2;
      4: v = hi + 16'($urandom_range(4)) - 16'd2;
      5, 6: v = (hi > lo) ? lo + 16'($urandom_range(hi - lo - 16'd1)) : 16'($urandom);
      7: begin
        case ($urandom_range(3))
          0: v = 16'h0000;
          1: v = 16'h00FF;
          2: v = 16'h0100;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    if (eight && $urandom_range(1)) v[15:8] = 8'($urandom);
    return v;
  endfunction

  initial begin
    logic [1:0]  mode;
    logic [15:0] lo;
    logic [15:0] hi;
    logic        eight;
    int          regime_items;
    int          burst;
    int          pause_at;

    send_idle_pct = 7;
    recv_idle_pct = 55;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset window: 8-bit grey bypass, upper bytes must be ignored
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 16'h1234, 16'hFFFF, 1'b1);
    send_pixel(16'h3A80, 16'h0000, 16'h0000, 1'b0);
    // RGB bypass
    set_window(wlg_pkg::MODE_RGB8, 16'd0, wlg_pkg::BYTE_MAX);
    send_pixel(16'h00FF, 16'h0000, 16'h007F, 1'b0);
    send_pixel(16'h12FF, 16'hABFE, 16'h00FD, 1'b1);
    // Full 16-bit window
    set_window(wlg_pkg::MODE_GREY16, 16'd0, 16'hFFFF);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'hFFFE, 16'h5555, 16'hAAAA, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // Window edges per channel
    set_window(wlg_pkg::MODE_RGB16, 16'd100, 16'd1000);
    send_pixel(16'd99, 16'd100, 16'd999, 1'b0);
    send_pixel(16'd1000, 16'hFFFF, 16'd0, 1'b1);
    // Inverted window
    set_window(wlg_pkg::MODE_GREY16, 16'd500, 16'd100);
    send_pixel(16'd499, 16'd0, 16'd0, 1'b0);
    send_pixel(16'd500, 16'd0, 16'd0, 1'b0);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 1'b1);
    // Empty window
    set_window(wlg_pkg::MODE_RGB16, 16'd300, 16'd300);
    send_pixel(16'd299, 16'd300, 16'd0, 1'b1);
    // Low border above the byte range in 8-bit mode
    set_window(wlg_pkg::MODE_GREY8, 16'd300, 16'd600);
    send_pixel(16'hFFFF, 16'h00FF, 16'h00FF, 1'b0);
    // Mapped RGB average
    set_window(wlg_pkg::MODE_RGB8, 16'd10, 16'd20);
    send_pixel(16'd9, 16'd15, 16'd20, 1'b0);
    send_pixel(16'd19, 16'd19, 16'd18, 1'b1);
    send_pixel(16'h0A0A, 16'h0B0B, 16'hFF13, 1'b0);
    // Register extremes
    set_window(wlg_pkg::MODE_RGB16, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFE, 16'h0000, 1'b1);
    set_window(wlg_pkg::MODE_GREY8, 16'd0, 16'd0);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);

    // Random windows under three pacing regimes
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin send_idle_pct = 7;  recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      regime_items = 0;
      while (regime_items < RANDOM_ITEMS / 3) begin
        pick_window(mode, lo, hi);
        set_window(mode, lo, hi);
        eight    = (mode == wlg_pkg::MODE_GREY8) || (mode == wlg_pkg::MODE_RGB8);
        burst    = $urandom_range(60, 25);
        pause_at = $urandom_range(burst - 1);
        for (int k = 0; k < burst; k++) begin
          // hold off mid-burst until the pipe is empty
          if (k == pause_at) drain_pipe();
          send_pixel(pick_sample(eight, lo, hi), pick_sample(eight, lo, hi),
                     pick_sample(eight, lo, hi), 1'($urandom_range(1)));
        end
        regime_items += burst;
      end
    end

    drain_pipe();
    repeat (PIPE_LATENCY * 3) @(posedge clk);

    $display("Checked %0d pixel words over %0d window settings (modes seen %b)",
             checked, windows_set, modes_seen);
    $display("Pacing: sender/receiver idle 7/55, 55/7 and 0/0 percent, drained mid-burst");
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
